FILE: rtl/scl_pkg.sv
// Shared types and constants for the skin color likelihood pipeline.
// Depends on nothing; the RTL files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

  // Pixel item: unsigned 8-bit components
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Result item: Q8.8 distance and Q0.16 likelihood
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] likelihood;
  } result_t;

  // Configuration register file as seen by the datapath
  typedef struct packed {
    logic        [15:0] blue_chroma_mean;
    logic        [15:0] red_chroma_mean;
    logic signed [23:0] inv_cov_rr;
    logic signed [23:0] inv_cov_rb;
    logic signed [23:0] inv_cov_bb;
  } cfg_t;

  // Register indexes on the write port
  localparam int unsigned REG_INDEX_W = 3;
  localparam int unsigned REG_DATA_W  = 24;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_BLUE_CHROMA_MEAN = 3'd0,
    REG_RED_CHROMA_MEAN  = 3'd1,
    REG_INV_COV_RR       = 3'd2,
    REG_INV_COV_RB       = 3'd3,
    REG_INV_COV_BB       = 3'd4
  } reg_index_t;

  // Reset values of the registers
  localparam logic        [15:0] RST_BLUE_CHROMA_MEAN = 16'd25381;
  localparam logic        [15:0] RST_RED_CHROMA_MEAN  = 16'd35345;
  localparam logic signed [23:0] RST_INV_COV_RR       = 24'sd63141;
  localparam logic signed [23:0] RST_INV_COV_RB       = -24'sd55487;
  localparam logic signed [23:0] RST_INV_COV_BB       = 24'sd93907;

  // Chroma delta, Q.8 signed
  typedef logic signed [16:0] delta_t;

  // Chroma conversion in Q.16 (BT.601 full range), 25-bit working width
  localparam int unsigned CHROMA_W = 25;
  localparam logic [CHROMA_W-1:0] CHROMA_OFFSET = 25'd8388608;
  localparam logic [CHROMA_W-1:0] CB_R_COEF     = 25'd11059;
  localparam logic [CHROMA_W-1:0] CB_G_COEF     = 25'd21709;
  localparam logic [CHROMA_W-1:0] CB_B_COEF     = 25'd32768;
  localparam logic [CHROMA_W-1:0] CR_R_COEF     = 25'd32768;
  localparam logic [CHROMA_W-1:0] CR_G_COEF     = 25'd27439;
  localparam logic [CHROMA_W-1:0] CR_B_COEF     = 25'd5329;
  localparam logic [CHROMA_W-1:0] CHROMA_ROUND  = 25'd128;

  // Table index: (distance * depth + half) >> shift
  localparam int unsigned LIK_IDX_SHIFT = 13;

  // exp(-1) in Q.32
  localparam logic [63:0] EXP_MINUS_ONE_Q32 = 64'd1580030169;

endpackage

`default_nettype wire

FILE: rtl/skin_color_likelihood_unit.sv
// Throughput: one pixel item per cycle; the eight register stages all advance
// every cycle, so busy never rises.
// Reset (rst, synchronous): clears every stage valid bit, dropping items in
// flight, and returns the configuration registers to their defaults.
// Top level: config registers and the chroma, quad-form and lookup stages.
// Depends on scl_pkg, scl_chroma, scl_quad_form, scl_lik_lookup.
`timescale 1ns / 1ps
`default_nettype none

module skin_color_likelihood_unit #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire scl_pkg::pixel_t                     pixel,
  input  wire logic                                wr_en,
  input  wire logic [scl_pkg::REG_INDEX_W-1:0]     wr_index,
  input  wire logic [scl_pkg::REG_DATA_W-1:0]      wr_data,
  output logic                                     done,
  output scl_pkg::result_t                         result
);

  localparam int unsigned LATENCY = 8;

  scl_pkg::cfg_t   cfg;
  logic            accept;
  logic            chroma_valid, quad_valid;
  scl_pkg::delta_t dr, db;
  logic [15:0]     distance;

  // The pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blue_chroma_mean <= scl_pkg::RST_BLUE_CHROMA_MEAN;
      cfg.red_chroma_mean  <= scl_pkg::RST_RED_CHROMA_MEAN;
      cfg.inv_cov_rr       <= scl_pkg::RST_INV_COV_RR;
      cfg.inv_cov_rb       <= scl_pkg::RST_INV_COV_RB;
      cfg.inv_cov_bb       <= scl_pkg::RST_INV_COV_BB;
    end else if (wr_en) begin
      case (scl_pkg::reg_index_t'(wr_index))
        scl_pkg::REG_BLUE_CHROMA_MEAN: cfg.blue_chroma_mean <= wr_data[15:0];
        scl_pkg::REG_RED_CHROMA_MEAN:  cfg.red_chroma_mean  <= wr_data[15:0];
        scl_pkg::REG_INV_COV_RR:       cfg.inv_cov_rr       <= wr_data;
        scl_pkg::REG_INV_COV_RB:       cfg.inv_cov_rb       <= wr_data;
        scl_pkg::REG_INV_COV_BB:       cfg.inv_cov_bb       <= wr_data;
        default: begin
        end
      endcase
    end
  end

  scl_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pixel     (pixel),
    .cfg       (cfg),
    .out_valid (chroma_valid),
    .dr        (dr),
    .db        (db)
  );

  scl_quad_form u_quad_form (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chroma_valid),
    .dr        (dr),
    .db        (db),
    .cfg       (cfg),
    .out_valid (quad_valid),
    .distance  (distance)
  );

  scl_lik_lookup #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_lik_lookup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quad_valid),
    .distance  (distance),
    .out_valid (done),
    .result    (result)
  );

  // Every result comes from a matching accepted item
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted item");

  // Every accepted item yields a result
  a_item_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted item produced no result");

  // Zero distance maps to full likelihood
  a_zero_distance: assert property (@(posedge clk) disable iff (rst)
    (done && result.distance == 16'd0) |-> result.likelihood == 16'hFFFF)
    else $error("zero distance without full likelihood");

  // Saturated distance lies past the table
  a_sat_distance: assert property (@(posedge clk) disable iff (rst)
    (done && result.distance == 16'hFFFF) |-> result.likelihood == 16'd0)
    else $error("saturated distance with nonzero likelihood");

endmodule

`default_nettype wire

FILE: rtl/scl_chroma.sv
// Chroma front end: RGB to Cb/Cr in Q.8 and mean subtraction, two stages.
// Depends on scl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scl_chroma (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire scl_pkg::pixel_t pixel,
  input  wire scl_pkg::cfg_t   cfg,
  output logic                 out_valid,
  output scl_pkg::delta_t      dr,
  output scl_pkg::delta_t      db
);

  localparam int unsigned W = scl_pkg::CHROMA_W;

  logic [W-1:0] r_ext, g_ext, b_ext;
  logic [W-1:0] cb16_next, cr16_next;
  logic [23:0]  cb16, cr16;
  logic         valid1;
  logic [W-1:0] cb_rnd, cr_rnd;
  logic [15:0]  cb8, cr8;
  scl_pkg::delta_t db_next, dr_next;

  // Form Cb and Cr in Q.16; true values stay inside 24 unsigned bits
  always_comb begin
    r_ext     = W'(pixel.red);
    g_ext     = W'(pixel.green);
    b_ext     = W'(pixel.blue);
    cb16_next = scl_pkg::CHROMA_OFFSET + b_ext * scl_pkg::CB_B_COEF
                - r_ext * scl_pkg::CB_R_COEF - g_ext * scl_pkg::CB_G_COEF;
    cr16_next = scl_pkg::CHROMA_OFFSET + r_ext * scl_pkg::CR_R_COEF
                - g_ext * scl_pkg::CR_G_COEF - b_ext * scl_pkg::CR_B_COEF;
  end

  // Stage 1: hold Q.16 chroma
  always_ff @(posedge clk) begin
    cb16 <= cb16_next[23:0];
    cr16 <= cr16_next[23:0];
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
  end

  // Round half up to Q.8 and subtract the configured means
  always_comb begin
    cb_rnd  = W'(cb16) + scl_pkg::CHROMA_ROUND;
    cr_rnd  = W'(cr16) + scl_pkg::CHROMA_ROUND;
    cb8     = cb_rnd[23:8];
    cr8     = cr_rnd[23:8];
    db_next = scl_pkg::delta_t'({1'b0, cb8} - {1'b0, cfg.blue_chroma_mean});
    dr_next = scl_pkg::delta_t'({1'b0, cr8} - {1'b0, cfg.red_chroma_mean});
  end

  // Stage 2: hold the deltas
  always_ff @(posedge clk) begin
    db <= db_next;
    dr <= dr_next;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/scl_quad_form.sv
// Mahalanobis quadratic form dr*(rr*dr + rb*db) + db*(rb*dr + bb*db), four
// stages, rounded and saturated to Q8.8. Depends on scl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scl_quad_form (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire scl_pkg::delta_t dr,
  input  wire scl_pkg::delta_t db,
  input  wire scl_pkg::cfg_t   cfg,
  output logic                 out_valid,
  output logic [15:0]          distance
);

  logic signed [40:0] rr_dr, rb_db, rb_dr, bb_db;
  scl_pkg::delta_t    dr3, db3, dr4, db4;
  logic               valid3, valid4, valid5;
  logic signed [41:0] u_sum, v_sum;
  logic signed [58:0] p_r, p_b;
  logic signed [59:0] q;
  logic        [59:0] q_rnd;
  logic        [15:0] dist_next;

  // Stage 3: coefficient products
  always_ff @(posedge clk) begin
    rr_dr <= cfg.inv_cov_rr * dr;
    rb_db <= cfg.inv_cov_rb * db;
    rb_dr <= cfg.inv_cov_rb * dr;
    bb_db <= cfg.inv_cov_bb * db;
    dr3   <= dr;
    db3   <= db;
    if (rst) begin
      valid3 <= 1'b0;
    end else begin
      valid3 <= in_valid;
    end
  end

  // Stage 4: row sums of the matrix-vector product
  always_ff @(posedge clk) begin
    u_sum <= 42'(rr_dr) + 42'(rb_db);
    v_sum <= 42'(rb_dr) + 42'(bb_db);
    dr4   <= dr3;
    db4   <= db3;
    if (rst) begin
      valid4 <= 1'b0;
    end else begin
      valid4 <= valid3;
    end
  end

  // Stage 5: second products
  always_ff @(posedge clk) begin
    p_r <= dr4 * u_sum;
    p_b <= db4 * v_sum;
    if (rst) begin
      valid5 <= 1'b0;
    end else begin
      valid5 <= valid4;
    end
  end

  // Clamp a negative form to zero, round Q.40 to Q8.8, saturate
  always_comb begin
    q     = 60'(p_r) + 60'(p_b);
    q_rnd = q[59] ? 60'd0 : (60'(q) + (60'd1 << 31));
    if (q_rnd[59:48] != 12'd0) begin
      dist_next = 16'hFFFF;
    end else begin
      dist_next = q_rnd[47:32];
    end
  end

  // Stage 6: hold the distance
  always_ff @(posedge clk) begin
    distance <= dist_next;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid5;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/scl_lik_lookup.sv
// Likelihood lookup: table index from the distance, then a registered read
// of the exp(-y) table built at elaboration. Depends on scl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scl_lik_lookup #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [15:0]      distance,
  output logic                  out_valid,
  output scl_pkg::result_t      result
);

  localparam int unsigned ADDR_W = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned PROD_W = 16 + ADDR_W + 1;
  localparam int unsigned IDX_W  = PROD_W - scl_pkg::LIK_IDX_SHIFT;

  typedef logic [15:0] lik_rom_t [EXP_TABLE_DEPTH];

  // Table entry i: round(65536*exp(-16*i/depth)), clamped to 65535
  function automatic lik_rom_t build_lik_rom();
    lik_rom_t    rom;
    logic [63:0] y, whole, frac, term, prod, r, v;
    longint      sum;
    for (int i = 0; i < int'(EXP_TABLE_DEPTH); i++) begin
      y     = (64'(i) << 36) / EXP_TABLE_DEPTH;
      whole = y >> 32;
      frac  = {32'd0, y[31:0]};
      term  = 64'd1 << 32;
      sum   = longint'(term);
      // Truncated Taylor series of exp(-frac)
      for (int k = 1; k <= 16; k++) begin
        prod = (term * frac) >> 32;
        case (k)
          1:       term = prod;
          2:       term = prod / 2;
          3:       term = prod / 3;
          4:       term = prod / 4;
          5:       term = prod / 5;
          6:       term = prod / 6;
          7:       term = prod / 7;
          8:       term = prod / 8;
          9:       term = prod / 9;
          10:      term = prod / 10;
          11:      term = prod / 11;
          12:      term = prod / 12;
          13:      term = prod / 13;
          14:      term = prod / 14;
          15:      term = prod / 15;
          default: term = prod / 16;
        endcase
        if ((k % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = 64'(sum);
      // Multiply in exp(-1) once per whole unit
      for (int w = 0; w < 16; w++) begin
        if (64'(w) < whole) begin
          r = (r * scl_pkg::EXP_MINUS_ONE_Q32 + (64'd1 << 31)) >> 32;
        end
      end
      v = (r + (64'd1 << 15)) >> 16;
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      rom[i] = v[15:0];
    end
    return rom;
  endfunction

  localparam lik_rom_t LIK_ROM = build_lik_rom();

  logic [PROD_W-1:0] scaled;
  logic [IDX_W-1:0]  idx_next;
  logic [ADDR_W-1:0] addr;
  logic              in_range;
  logic [15:0]       dist7;
  logic              valid7;

  // Scale the distance onto the table span, rounding half up
  always_comb begin
    scaled   = PROD_W'(distance) * PROD_W'(EXP_TABLE_DEPTH)
               + (PROD_W'(1) << (scl_pkg::LIK_IDX_SHIFT - 1));
    idx_next = scaled[PROD_W-1:scl_pkg::LIK_IDX_SHIFT];
  end

  // Stage 7: hold the table address and range flag
  always_ff @(posedge clk) begin
    addr     <= idx_next[ADDR_W-1:0];
    in_range <= idx_next < IDX_W'(EXP_TABLE_DEPTH);
    dist7    <= distance;
    if (rst) begin
      valid7 <= 1'b0;
    end else begin
      valid7 <= in_valid;
    end
  end

  // Stage 8: registered table read; past the table the likelihood is zero
  always_ff @(posedge clk) begin
    result.distance <= dist7;
    if (in_range) begin
      result.likelihood <= LIK_ROM[addr];
    end else begin
      result.likelihood <= 16'd0;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid7;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for skin_color_likelihood_unit: pixel items go in,
// and each distance/likelihood result is compared against a fixed-point predictor.
// Depends on scl_pkg and the skin_color_likelihood_unit RTL.
`timescale 1ns / 1ps

module tb_top;
  import scl_pkg::*;

  localparam int LIK_TABLE_DEPTH = 256;
  localparam int NUM_REGS        = int'(REG_INV_COV_BB) + 1;
  localparam int PIPE_LATENCY    = 8;
  localparam int ITEMS_PER_PHASE = 103;
  localparam int MAX_REPORTS     = 40;

  typedef enum {SET_DEFAULT, SET_NEAR, SET_SATURATE, SET_NEGATIVE, SET_ZERO, SET_WIDE} setting_e;

  localparam setting_e PHASES [11] = '{SET_DEFAULT, SET_NEAR, SET_SATURATE, SET_NEAR,
                                       SET_NEGATIVE, SET_WIDE, SET_NEAR, SET_ZERO,
                                       SET_WIDE, SET_NEAR, SET_DEFAULT};

  // Primaries, corners, gray and a handful of skin tones
  localparam logic [23:0] DIRECTED_PIXELS [18] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'hFF00FF, 24'h00FFFF, 24'h808080, 24'h7F7F7F, 24'hE0AC8A, 24'hC68642,
    24'h8D5524, 24'hFFDBAC, 24'hF1C27D, 24'hE8BEAC, 24'h010204, 24'hFE7F01};

  // Predicts distance and likelihood per pixel and holds them until they come out
  class likelihood_scoreboard;
    longint       mean_b, mean_r, k_rr, k_rb, k_bb;
    logic [15:0]  lik_table [LIK_TABLE_DEPTH];
    result_t      awaited_results [$];
    int           mismatch_count;

    function new();
      longint unsigned y, v;
      mean_b = RST_BLUE_CHROMA_MEAN;
      mean_r = RST_RED_CHROMA_MEAN;
      k_rr   = RST_INV_COV_RR;
      k_rb   = RST_INV_COV_RB;
      k_bb   = RST_INV_COV_BB;
      mismatch_count = 0;
      // exp(-y) sampled over distances 0..32, y = i*16/depth
      for (int i = 0; i < LIK_TABLE_DEPTH; i++) begin
        y = (longint'(i) << 36) / LIK_TABLE_DEPTH;
        v = (exp_neg_fixed(y) + (64'd1 << 15)) >> 16;
        if (v > 65535) v = 65535;
        lik_table[i] = v[15:0];
      end
    endfunction

    // exp(-y) in Q.32: Taylor series on the fraction, times exp(-1) per whole unit
    function longint unsigned exp_neg_fixed(longint unsigned y);
      longint unsigned whole, frac, term, r;
      longint          sum;
      whole = y >> 32;
      frac  = y & 64'hFFFF_FFFF;
      term  = 64'd1 << 32;
      sum   = longint'(term);
      for (int k = 1; k <= 16; k++) begin
        term = ((term * frac) >> 32) / longint'(k);
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      r = longint'(sum);
      for (longint unsigned k = 0; k < whole; k++)
        r = (r * EXP_MINUS_ONE_Q32 + (64'd1 << 31)) >> 32;
      return r;
    endfunction

    function void set_reg(reg_index_t idx, logic [REG_DATA_W-1:0] data);
      case (idx)
        REG_BLUE_CHROMA_MEAN: mean_b = longint'(data[15:0]);
        REG_RED_CHROMA_MEAN:  mean_r = longint'(data[15:0]);
        REG_INV_COV_RR:       k_rr   = longint'(signed'(data));
        REG_INV_COV_RB:       k_rb   = longint'(signed'(data));
        REG_INV_COV_BB:       k_bb   = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    // Cb and Cr in Q.8, rounded half up from Q.16
    function void chroma(input pixel_t px, output longint cb, output longint cr);
      longint r, g, b;
      r  = longint'(px.red);
      g  = longint'(px.green);
      b  = longint'(px.blue);
      cb = (8388608 - 11059 * r - 21709 * g + 32768 * b + 128) >>> 8;
      cr = (8388608 + 32768 * r - 27439 * g - 5329 * b + 128) >>> 8;
    endfunction

    function result_t predict_likelihood(pixel_t px);
      longint  cb, cr, db, dr, q, dist_val, idx;
      result_t res;
      chroma(px, cb, cr);
      db = cb - mean_b;
      dr = cr - mean_r;
      q  = k_rr * (dr * dr) + 2 * k_rb * (dr * db) + k_bb * (db * db);
      // treat a negative form as zero
      if (q < 0) q = 0;
      dist_val = (q + 64'sd2147483648) >>> 32;
      if (dist_val > 65535) dist_val = 65535;
      idx = (dist_val * LIK_TABLE_DEPTH + 4096) >>> LIK_IDX_SHIFT;
      res.distance   = dist_val[15:0];
      res.likelihood = (idx < LIK_TABLE_DEPTH) ? lik_table[idx] : 16'd0;
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      awaited_results.push_back(predict_likelihood(px));
    endfunction

    function void report(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result dist=%0d lik=%0d", got.distance, got.likelihood));
        return;
      end
      want = awaited_results.pop_front();
      if (got.distance !== want.distance)
        report($sformatf("distance %0d, expected %0d", got.distance, want.distance));
      if (got.likelihood !== want.likelihood)
        report($sformatf("likelihood %0d, expected %0d", got.likelihood, want.likelihood));
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  pixel_t                 pixel;
  logic                   wr_en;
  logic [REG_INDEX_W-1:0] wr_index;
  logic [REG_DATA_W-1:0]  wr_data;
  logic                   done;
  result_t                result;

  likelihood_scoreboard   sb;
  logic [REG_DATA_W-1:0]  reg_vals [NUM_REGS];
  int                     near_phases = 0;

  skin_color_likelihood_unit #(
    .EXP_TABLE_DEPTH(LIK_TABLE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pixel(pixel),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .done(done),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Note each accepted item and check each strobed result
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_pixel(pixel);
    if (!rst && done) sb.check_result(result);
  end

  // Hold start and the pixel until the block takes the item
  task automatic send_pixel(input pixel_t px);
    start <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (busy);
  endtask

  // Drain all results, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk); while (sb.pending() > 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  function automatic int clamp_u16(longint v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return int'(v);
  endfunction

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap(bit idle_on);
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Near the center pixel, uniform, or each component 0, 255 or random
  function automatic pixel_t rand_pixel(pixel_t center);
    logic [7:0] ctr  [3];
    logic [7:0] comp [3];
    int         mode, v, pick;
    ctr  = '{center.red, center.green, center.blue};
    mode = $urandom_range(0, 3);
    for (int c = 0; c < 3; c++) begin
      if (mode < 2) begin
        v = int'(ctr[c]) + int'($urandom_range(0, 32)) - 16;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        comp[c] = v[7:0];
      end else if (mode == 2) begin
        comp[c] = 8'($urandom());
      end else begin
        pick = $urandom_range(0, 2);
        comp[c] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom());
      end
    end
    return {comp[0], comp[1], comp[2]};
  endfunction

  // Program all registers for one setting, plus a write to an unused index
  task automatic configure(input setting_e kind, input pixel_t center);
    longint cb, cr;
    int     off_b, off_r, rr, bb, lim, rb;
    wait_idle();
    case (kind)
      SET_DEFAULT: begin
        reg_vals[REG_BLUE_CHROMA_MEAN] = {8'h00, RST_BLUE_CHROMA_MEAN};
        reg_vals[REG_RED_CHROMA_MEAN]  = {8'h00, RST_RED_CHROMA_MEAN};
        reg_vals[REG_INV_COV_RR]       = RST_INV_COV_RR;
        reg_vals[REG_INV_COV_RB]       = RST_INV_COV_RB;
        reg_vals[REG_INV_COV_BB]       = RST_INV_COV_BB;
      end
      SET_NEAR: begin
        // means at or near one pixel's chroma (offset after the first time), positive definite matrix
        sb.chroma(center, cb, cr);
        off_b = (near_phases == 0) ? 0 : int'($urandom_range(0, 1024)) - 512;
        off_r = (near_phases == 0) ? 0 : int'($urandom_range(0, 1024)) - 512;
        near_phases++;
        rr  = $urandom_range(2000, 600000);
        bb  = $urandom_range(2000, 600000);
        lim = ((rr < bb) ? rr : bb) / 2;
        rb  = int'($urandom_range(0, 2 * lim)) - lim;
        reg_vals[REG_BLUE_CHROMA_MEAN] = 24'(clamp_u16(cb + off_b));
        reg_vals[REG_RED_CHROMA_MEAN]  = 24'(clamp_u16(cr + off_r));
        reg_vals[REG_INV_COV_RR]       = rr[23:0];
        reg_vals[REG_INV_COV_RB]       = rb[23:0];
        reg_vals[REG_INV_COV_BB]       = bb[23:0];
      end
      SET_SATURATE: begin
        reg_vals[REG_BLUE_CHROMA_MEAN] = 24'h00FFFF;
        reg_vals[REG_RED_CHROMA_MEAN]  = 24'h000000;
        reg_vals[REG_INV_COV_RR]       = 24'h7FFFFF;
        reg_vals[REG_INV_COV_RB]       = 24'h800000;
        reg_vals[REG_INV_COV_BB]       = 24'h7FFFFF;
      end
      SET_NEGATIVE: begin
        reg_vals[REG_BLUE_CHROMA_MEAN] = 24'h000000;
        reg_vals[REG_RED_CHROMA_MEAN]  = 24'h00FFFF;
        reg_vals[REG_INV_COV_RR]       = 24'h800000;
        reg_vals[REG_INV_COV_RB]       = 24'h7FFFFF;
        reg_vals[REG_INV_COV_BB]       = 24'h800000;
      end
      SET_ZERO: begin
        for (int k = 0; k < NUM_REGS; k++) reg_vals[k] = '0;
      end
      default: begin
        // full-width random data, upper bits of the mean writes included
        for (int k = 0; k < NUM_REGS; k++) reg_vals[k] = 24'($urandom());
      end
    endcase
    for (int k = 0; k < NUM_REGS; k++) begin
      wr_en    <= 1'b1;
      wr_index <= REG_INDEX_W'(k);
      wr_data  <= reg_vals[k];
      @(posedge clk);
      sb.set_reg(reg_index_t'(k), reg_vals[k]);
    end
    wr_index <= REG_INDEX_W'($urandom_range(NUM_REGS, (1 << REG_INDEX_W) - 1));
    wr_data  <= 24'($urandom());
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin
    setting_e kind;
    pixel_t   center;
    bit       idle_on, drain;
    int       gap;
    sb       = new();
    rst      = 1'b1;
    start    = 1'b0;
    pixel    = '0;
    wr_en    = 1'b0;
    wr_index = '0;
    wr_data  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < $size(PHASES); ph++) begin
      kind   = PHASES[ph];
      center = 24'($urandom());
      if (ph > 0) configure(kind, center);
      idle_on = (ph % 3 != 1);
      if (ph == 0) begin
        for (int k = 0; k < $size(DIRECTED_PIXELS); k++) send_pixel(DIRECTED_PIXELS[k]);
      end
      if (kind == SET_NEAR) send_pixel(center);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_pixel(rand_pixel(center));
        gap   = pick_gap(idle_on);
        drain = ($urandom_range(0, 59) == 0);
        if (gap > 0 || drain) start <= 1'b0;
        repeat (gap) @(posedge clk);
        // now and then hold off until every result is back
        if (drain) begin
          do @(posedge clk); while (sb.pending() > 0);
        end
      end
      start <= 1'b0;
    end

    do @(posedge clk); while (sb.pending() > 0);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/scl_pkg.sv
rtl/scl_chroma.sv
rtl/scl_quad_form.sv
rtl/scl_lik_lookup.sv
rtl/skin_color_likelihood_unit.sv
tb/tb_top.sv
